// ----- hdl/serm_pkg.sv -----
// serm_pkg: shared types and constants for the event rate monitor
// no dependencies
package serm_pkg;

	localparam int NUM_CHANNELS  = 8;
	localparam int FIFO_DEPTH    = 64;
	localparam int TICKS_PER_SEC = 1000;

	localparam int CH_W    = 3;
	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int CNT_W   = PTR_W + 1;
	localparam int ADDR_W  = CH_W + PTR_W;
	localparam int RATE_W  = 23;
	localparam int DIV_W   = 32;

	localparam logic [14:0] WIN_LOW     = 15'd2000;
	localparam logic [14:0] WIN_HIGH    = 15'd30000;
	localparam logic [14:0] WIN_RESET   = 15'd10000;
	localparam logic [13:0] STALE_LOW   = 14'd500;
	localparam logic [13:0] STALE_HIGH  = 14'd10000;
	localparam logic [13:0] STALE_RESET = 14'd2000;
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	localparam logic [31:0] RATE_SCALE = 32'(100 * TICKS_PER_SEC);

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_REPORT  = 1'b1;

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_STALE  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  channel;
		logic [31:0] now_ticks;
	} in_word_t;

	typedef struct packed {
		logic [2:0]        report_channel;
		logic [RATE_W-1:0] rate_centihz;
		logic [31:0]       age_ticks;
		logic              received;
		logic              stale;
		logic              last;
	} out_word_t;

	// divider start request
	typedef struct packed {
		logic              start;
		logic [DIV_W+1:0]  num;
		logic [DIV_W+1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_W+1:0]  quo;
	} div_rsp_t;

endpackage

// ----- hdl/sensor_event_rate_monitor.sv -----
// sensor_event_rate_monitor: per-channel sliding window rate and staleness monitor
// depends on serm_pkg and serm_div
// arrival: push the stamp, then prune stale stamps; report: per channel, prune, then read the newest
// stamp and, when a rate is needed, run the serial divider; a line waits for ready
// one word in flight at a time, set by the shared stamp memory port and divider
// reset clears registers, counts, flags and last-arrival times; stamp memory is not cleared
module sensor_event_rate_monitor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  serm_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output serm_pkg::out_word_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import serm_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PUSH   = 9'b000000010,
		S_PRD    = 9'b000000100,
		S_PCHK   = 9'b000001000,
		S_RDNEW  = 9'b000010000,
		S_LATNEW = 9'b000100000,
		S_DIV    = 9'b001000000,
		S_WAITD  = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q;
	logic [14:0] window_q;
	logic [13:0] stale_q;

	logic [31:0]      mem [NUM_CHANNELS*FIFO_DEPTH];
	logic [31:0]      rd_q;
	logic             we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic             re;

	logic [PTR_W-1:0] head_q [NUM_CHANNELS];
	logic [CNT_W-1:0] count_q [NUM_CHANNELS];
	logic [31:0]      last_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] seen_q;

	logic             op_q;
	logic [CH_W-1:0]  ch_q;
	logic [31:0]      now_q;
	logic [31:0]      oldest_q;
	out_word_t        out_q;
	logic             out_valid_q;

	div_req_t dreq;
	div_rsp_t drsp;

	serm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// apb registers with clamping
	logic        wr_en;
	logic [14:0] wv;
	logic [13:0] sv;
	assign wr_en = psel && penable && pwrite;
	assign wv = pwdata[14:0];
	assign sv = pwdata[13:0];
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
			stale_q  <= STALE_RESET;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_WINDOW)
				window_q <= (wv < WIN_LOW) ? WIN_LOW : (wv > WIN_HIGH) ? WIN_HIGH : wv;
			else
				stale_q <= (sv < STALE_LOW) ? STALE_LOW : (sv > STALE_HIGH) ? STALE_HIGH : sv;
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINDOW)
			prdata = {17'd0, window_q};
		else
			prdata = {18'd0, stale_q};
	end

	// current channel view
	logic [PTR_W-1:0] head_c;
	logic [CNT_W-1:0] cnt_c;
	logic             prune_hit;
	logic [PTR_W-1:0] newest_ptr;
	assign head_c = head_q[ch_q];
	assign cnt_c  = count_q[ch_q];
	assign prune_hit = (now_q > rd_q) && ((now_q - rd_q) > {17'd0, window_q});
	assign newest_ptr = head_c + PTR_W'(cnt_c - 1'b1);

	// stamp memory, one write and one read port; read data held between reads
	always_comb begin
		we = (state_q == S_PUSH);
		waddr = {ch_q, PTR_W'(head_c + PTR_W'(cnt_c))};
		re = (state_q == S_PRD) || (state_q == S_RDNEW);
		raddr = {ch_q, head_c};
		if (state_q == S_RDNEW)
			raddr = {ch_q, newest_ptr};
	end
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= now_q;
		if (re)
			rd_q <= mem[raddr];
	end

	// rate and age for the current channel
	logic [31:0] span;
	logic [31:0] age;
	logic [DIV_W+1:0] numer;
	assign span = rd_q - oldest_q;
	assign numer = (DIV_W+2)'({(cnt_c - 1'b1), 1'b0}) * (DIV_W+2)'(RATE_SCALE);
	assign age = (seen_q[ch_q] && now_q > last_q[ch_q]) ? now_q - last_q[ch_q] : 32'd0;

	always_comb begin
		dreq.start = (state_q == S_DIV);
		dreq.num = numer + {2'b00, span};
		dreq.den = {1'b0, span, 1'b0};
	end

	// result register loads when empty or being emptied
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q <= '0;
			out_valid_q <= 1'b0;
			op_q <= OP_ARRIVAL;
			ch_q <= '0;
			now_q <= '0;
			oldest_q <= '0;
			out_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && !out_load)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= in_data.opcode;
						ch_q <= (in_data.opcode == OP_REPORT) ? '0 : in_data.channel;
						now_q <= in_data.now_ticks;
						state_q <= (in_data.opcode == OP_REPORT) ? S_PRD : S_PUSH;
					end
				end
				S_PUSH: begin
					if (cnt_c == CNT_W'(FIFO_DEPTH)) begin
						head_q[ch_q] <= head_c + 1'b1;
					end else begin
						count_q[ch_q] <= cnt_c + 1'b1;
					end
					last_q[ch_q] <= now_q;
					seen_q[ch_q] <= 1'b1;
					state_q <= S_PRD;
				end
				S_PRD: begin
					// read issues this cycle for head
					if (cnt_c == '0)
						state_q <= (op_q == OP_REPORT) ? S_OUT : S_IDLE;
					else
						state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (prune_hit) begin
						head_q[ch_q] <= head_c + 1'b1;
						count_q[ch_q] <= cnt_c - 1'b1;
						state_q <= S_PRD;
					end else if (op_q == OP_ARRIVAL) begin
						state_q <= S_IDLE;
					end else begin
						oldest_q <= rd_q;
						state_q <= (cnt_c >= CNT_W'(2)) ? S_RDNEW : S_OUT;
					end
				end
				S_RDNEW: state_q <= S_LATNEW;
				S_LATNEW: state_q <= (rd_q > oldest_q) ? S_DIV : S_OUT;
				S_DIV: state_q <= S_WAITD;
				S_WAITD: begin
					if (drsp.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_q.report_channel <= ch_q;
						out_q.age_ticks <= age;
						out_q.received <= seen_q[ch_q];
						out_q.stale <= !seen_q[ch_q] || (age > {18'd0, stale_q});
						out_q.last <= (ch_q == CH_W'(NUM_CHANNELS-1));
						out_q.rate_centihz <= '0;
						if (cnt_c >= CNT_W'(2) && rd_q > oldest_q)
							out_q.rate_centihz <= (drsp.quo > (DIV_W+2)'(RATE_MAX)) ?
								RATE_MAX : drsp.quo[RATE_W-1:0];
						out_valid_q <= 1'b1;
						if (ch_q == CH_W'(NUM_CHANNELS-1)) begin
							state_q <= S_IDLE;
						end else begin
							ch_q <= ch_q + 1'b1;
							state_q <= S_PRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_out_while_idle_arr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH |-> $past(state_q) == S_IDLE) else $error("push out of order");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[ch_q] <= CNT_W'(FIFO_DEPTH)) else $error("fifo count overflow");
	a_wait_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAITD |-> drsp.busy || drsp.done) else $error("divider idle in wait");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("result word dropped");
`endif

endmodule

// ----- hdl/serm_div.sv -----
// serm_div: radix-2 restoring divider, one quotient bit per cycle
// depends on serm_pkg
module serm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  serm_pkg::div_req_t req,
	output serm_pkg::div_rsp_t rsp
);
	import serm_pkg::*;

	localparam int W = DIV_W + 2;
	localparam int N_W = $clog2(W + 1);

	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic [N_W-1:0] n_q;
	logic busy_q;
	logic done_q;
	logic [W:0] trial;

	// shift in next numerator bit and try subtract
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				n_q    <= N_W'(W);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == N_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> busy_q || done_q) else $error("divider lost run");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_W'(W)) else $error("divider count overrun");
`endif

endmodule
